@@ rtl/hue_bucketed_palette_reducer_defines.svh @@
// ----------------------------------------------------------------------------
// hue_bucketed_palette_reducer_defines.svh
// Assertion macros used by the palette reducer top level.
// ----------------------------------------------------------------------------
`ifndef HUE_BUCKETED_PALETTE_REDUCER_DEFINES_SVH
`define HUE_BUCKETED_PALETTE_REDUCER_DEFINES_SVH

// same-cycle implication, checked on i_clk, off during reset
`define HBPR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on i_clk, off during reset
`define HBPR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/hbpr_pkg.sv @@
// ----------------------------------------------------------------------------
// hbpr_pkg
// Types, constants and helper functions of the hue bucketed palette reducer.
// ----------------------------------------------------------------------------
`default_nettype none

package hbpr_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int HUE_TABLES      = 6;
    localparam logic [7:0] LIMIT_RESET = 8'd216;
    localparam int DIV_STEPS       = 17;

    // hue centers of the six tables
    localparam logic signed [10:0] HUE_CENTER [HUE_TABLES] =
        '{11'sd0, 11'sd30, 11'sd60, 11'sd90, 11'sd240, 11'sd270};

    typedef struct packed {
        logic       mode;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] run_count;
        logic [2:0] read_bucket;
        logic [7:0] read_slot;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  bucket;
        logic        was_new;
        logic        merged;
        logic        entry_valid;
        logic [7:0]  entry_red;
        logic [7:0]  entry_green;
        logic [7:0]  entry_blue;
        logic [31:0] entry_frequency;
        logic [8:0]  total_entries;
    } t_out_item;

    // one stored palette entry
    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [31:0] count;
    } t_entry;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_DIV_INIT,
        CMD_DIV_STEP,
        CMD_PICK,
        CMD_MATCH_SCAN,
        CMD_UPDATE,
        CMD_BIG,
        CMD_TOP_SCAN,
        CMD_NEAR_INIT,
        CMD_NEAR_SCAN,
        CMD_MERGE,
        CMD_SHIFT,
        CMD_DROP,
        CMD_READ,
        CMD_READ_CAP
    } t_cmd;

    typedef enum logic [0:0] {
        OUT_HOLD,
        OUT_LOAD
    } t_out_ctl;

    typedef struct packed {
        logic div_done;
        logic scan_done;
        logic over_limit;
        logic big_nonempty;
        logic mode_read;
        logic out_busy;
    } t_status;

    // saturating 32-bit add
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // first nearest hue center
    function automatic logic [2:0] nearest_table(input logic signed [9:0] hue);
        logic [2:0]        best;
        logic signed [10:0] diff;
        logic [10:0]       best_diff;
        best      = 3'd0;
        best_diff = 11'h7FF;
        for (int k = 0; k < HUE_TABLES; k++) begin
            diff = 11'(hue) - HUE_CENTER[k];
            if (diff < 0) diff = -diff;
            if (11'(diff) < best_diff) begin
                best_diff = 11'(diff);
                best      = 3'(k);
            end
        end
        return best;
    endfunction

endpackage

`default_nettype wire

@@ rtl/hbpr_ram.sv @@
// ----------------------------------------------------------------------------
// hbpr_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hbpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/hbpr_ctrl.sv @@
// ----------------------------------------------------------------------------
// hbpr_ctrl
// Sequencer of the palette reducer: steps each item through its phases.
// ----------------------------------------------------------------------------
`default_nettype none

module hbpr_ctrl import hbpr_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_status i_status,
    output t_cmd         o_cmd,
    output t_out_ctl     o_out_ctl,
    output logic         o_busy
);

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_READ, S_READ_CAP, S_DIV_INIT, S_DIV, S_PICK, S_MATCH,
        S_UPDATE, S_CHECK, S_BIG, S_TOP, S_NEAR_INIT, S_NEAR, S_MERGE, S_SHIFT,
        S_DROP, S_RESP
    } t_state;

    t_state r_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE:      if (i_in_valid) r_state <= S_DECODE;
                S_DECODE:    r_state <= i_status.mode_read ? S_READ : S_DIV_INIT;
                S_READ:      r_state <= S_READ_CAP;
                S_READ_CAP:  r_state <= S_RESP;
                S_DIV_INIT:  r_state <= S_DIV;
                S_DIV:       if (i_status.div_done) r_state <= S_PICK;
                S_PICK:      r_state <= S_MATCH;
                S_MATCH:     if (i_status.scan_done) r_state <= S_UPDATE;
                S_UPDATE:    r_state <= S_CHECK;
                S_CHECK:     r_state <= i_status.over_limit ? S_BIG : S_RESP;
                S_BIG:       r_state <= i_status.big_nonempty ? S_TOP : S_RESP;
                S_TOP:       if (i_status.scan_done) r_state <= S_NEAR_INIT;
                S_NEAR_INIT: r_state <= S_NEAR;
                S_NEAR:      if (i_status.scan_done) r_state <= S_MERGE;
                S_MERGE:     r_state <= S_SHIFT;
                S_SHIFT:     if (i_status.scan_done) r_state <= S_DROP;
                S_DROP:      r_state <= S_RESP;
                S_RESP:      if (!i_status.out_busy) r_state <= S_IDLE;
                default:     r_state <= S_IDLE;
            endcase
        end
    end

    // command decode
    always_comb begin
        o_out_ctl = OUT_HOLD;
        unique case (r_state)
            S_IDLE:      o_cmd = CMD_LOAD;
            S_READ:      o_cmd = CMD_READ;
            S_READ_CAP:  o_cmd = CMD_READ_CAP;
            S_DIV_INIT:  o_cmd = CMD_DIV_INIT;
            S_DIV:       o_cmd = CMD_DIV_STEP;
            S_PICK:      o_cmd = CMD_PICK;
            S_MATCH:     o_cmd = CMD_MATCH_SCAN;
            S_UPDATE:    o_cmd = CMD_UPDATE;
            S_BIG:       o_cmd = CMD_BIG;
            S_TOP:       o_cmd = CMD_TOP_SCAN;
            S_NEAR_INIT: o_cmd = CMD_NEAR_INIT;
            S_NEAR:      o_cmd = CMD_NEAR_SCAN;
            S_MERGE:     o_cmd = CMD_MERGE;
            S_SHIFT:     o_cmd = CMD_SHIFT;
            S_DROP:      o_cmd = CMD_DROP;
            S_RESP: begin
                o_cmd = CMD_NONE;
                if (!i_status.out_busy) o_out_ctl = OUT_LOAD;
            end
            default:     o_cmd = CMD_NONE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

@@ rtl/hbpr_dp.sv @@
// ----------------------------------------------------------------------------
// hbpr_dp
// Datapath: hue divider, table fills, entry RAM scans, merge and output.
// ----------------------------------------------------------------------------
`default_nettype none

module hbpr_dp import hbpr_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cmd       i_cmd,
    input  wire t_out_ctl   i_out_ctl,
    output t_status         o_status,
    input  wire logic       i_in_valid,
    input  wire t_in_item   i_in_item,
    input  wire logic [7:0] i_palette_limit,
    input  wire logic       i_out_stall,
    output logic            o_out_valid,
    output t_out_item       o_out_item
);

    localparam int SLOT_W    = $clog2(TABLE_DEPTH);
    localparam int FILL_W    = $clog2(TABLE_DEPTH + 1);
    localparam int MEM_DEPTH = HUE_TABLES * TABLE_DEPTH;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int SUM_W     = FILL_W + 3;
    localparam int ENT_W     = $bits(t_entry);

    t_in_item          r_item;
    logic [FILL_W-1:0] r_fill [HUE_TABLES];
    logic [2:0]        r_tbl;
    // table picked by the hue, kept through a merge
    logic [2:0]        r_pick;
    // divider
    logic [16:0]       r_num;
    logic [7:0]        r_den;
    logic [7:0]        r_rem;
    logic [16:0]       r_quo;
    logic              r_neg;
    logic [4:0]        r_dcnt;
    // scan pipeline
    logic [FILL_W-1:0] r_idx;
    logic              r_dv;
    logic [SLOT_W-1:0] r_didx;
    logic              r_found;
    logic [SLOT_W-1:0] r_hit;
    logic [31:0]       r_hitcnt;
    logic [SLOT_W-1:0] r_top;
    t_entry            r_top_ent;
    logic [15:0]       r_sq_r, r_sq_g, r_sq_b;
    logic              r_dv2;
    logic [SLOT_W-1:0] r_didx2;
    logic [31:0]       r_cnt2;
    logic [17:0]       r_best;
    logic [SLOT_W-1:0] r_near;
    logic [31:0]       r_nearcnt;
    // result flags and read data
    logic              r_was_new, r_merged, r_rd_ok;
    t_entry            r_ent;
    logic              r_ovalid;
    t_out_item         r_out;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    t_entry            ram_wdata, ram_rdata;
    logic [ENT_W-1:0]  ram_rdata_bits;

    function automatic logic [AW-1:0] addr_of(input logic [2:0] tbl,
                                              input logic [SLOT_W-1:0] slot);
        return AW'(AW'(tbl) * AW'(TABLE_DEPTH)) + AW'(slot);
    endfunction

    hbpr_ram #(.WIDTH(ENT_W), .DEPTH(MEM_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata_bits)
    );
    assign ram_rdata = t_entry'(ram_rdata_bits);

    // fill of the selected table, total fill and largest table
    logic [FILL_W-1:0] n_sel;
    logic [SUM_W-1:0]  fill_sum;
    logic [2:0]        big;
    logic [FILL_W-1:0] rb_fill;
    logic              rd_ok_c;
    always_comb begin
        n_sel    = r_fill[r_tbl];
        fill_sum = '0;
        big      = 3'd0;
        rb_fill  = '0;
        for (int k = 0; k < HUE_TABLES; k++) begin
            fill_sum = fill_sum + SUM_W'(r_fill[k]);
            if (r_item.read_bucket == 3'(k)) rb_fill = r_fill[k];
        end
        for (int k = 1; k < HUE_TABLES; k++) begin
            if (r_fill[big] < r_fill[k]) big = 3'(k);
        end
        rd_ok_c = (r_item.read_bucket < 3'(HUE_TABLES)) &&
                  (32'(r_item.read_slot) < 32'(rb_fill));
    end

    // hue from divider result
    logic signed [9:0] hue;
    assign hue = r_neg ? -$signed({1'b0, r_quo[8:0]}) : $signed({1'b0, r_quo[8:0]});

    // divider setup from the colour
    logic [7:0]  mx, mn, dd8;
    logic [16:0] init_num;
    logic        init_neg;
    always_comb begin
        mx = r_item.red;
        if (r_item.green > mx) mx = r_item.green;
        if (r_item.blue > mx)  mx = r_item.blue;
        mn = r_item.red;
        if (r_item.green < mn) mn = r_item.green;
        if (r_item.blue < mn)  mn = r_item.blue;
        dd8      = mx - mn;
        init_neg = 1'b0;
        if (dd8 == 8'd0) begin
            init_num = '0;
        end else if (mx == r_item.red) begin
            init_neg = r_item.green < r_item.blue;
            init_num = 17'd60 * (init_neg ? {9'd0, r_item.blue - r_item.green}
                                          : {9'd0, r_item.green - r_item.blue});
        end else if (mx == r_item.green) begin
            init_num = 17'd120 * {9'd0, dd8} + 17'd60 * {9'd0, r_item.blue}
                     - 17'd60 * {9'd0, r_item.red};
        end else begin
            init_num = 17'd240 * {9'd0, dd8} + 17'd60 * {9'd0, r_item.red}
                     - 17'd60 * {9'd0, r_item.green};
        end
    end

    // one restoring divide step
    logic [8:0] div_t;
    logic       div_bit;
    assign div_t   = {r_rem, r_num[16]};
    assign div_bit = (div_t >= {1'b0, r_den});

    // read issue for scans
    logic is_scan, issue;
    assign is_scan = (i_cmd == CMD_MATCH_SCAN) || (i_cmd == CMD_TOP_SCAN) ||
                     (i_cmd == CMD_NEAR_SCAN) || (i_cmd == CMD_SHIFT);
    assign issue   = is_scan && (r_idx < n_sel) && !((i_cmd == CMD_MATCH_SCAN) && r_found);

    // squared distance to the top entry: squares of the differences, then the sum of the registered squares
    logic signed [8:0]  df_r, df_g, df_b;
    logic signed [17:0] p_r, p_g, p_b;
    logic [17:0]        sq_dist;
    always_comb begin
        df_r = $signed({1'b0, r_top_ent.red})   - $signed({1'b0, ram_rdata.red});
        df_g = $signed({1'b0, r_top_ent.green}) - $signed({1'b0, ram_rdata.green});
        df_b = $signed({1'b0, r_top_ent.blue})  - $signed({1'b0, ram_rdata.blue});
        p_r  = df_r * df_r;
        p_g  = df_g * df_g;
        p_b  = df_b * df_b;
        sq_dist = 18'(r_sq_r) + 18'(r_sq_g) + 18'(r_sq_b);
    end

    // RAM address and write selection
    always_comb begin
        ram_raddr = '0;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        unique case (i_cmd)
            CMD_READ: begin
                if (rd_ok_c) ram_raddr = addr_of(r_item.read_bucket, SLOT_W'(r_item.read_slot));
            end
            CMD_MATCH_SCAN, CMD_TOP_SCAN, CMD_NEAR_SCAN: begin
                ram_raddr = addr_of(r_tbl, r_idx[SLOT_W-1:0]);
            end
            CMD_SHIFT: begin
                ram_raddr = addr_of(r_tbl, r_idx[SLOT_W-1:0]);
                ram_we    = r_dv;
                ram_waddr = addr_of(r_tbl, r_didx - SLOT_W'(1));
                ram_wdata = ram_rdata;
            end
            CMD_UPDATE: begin
                ram_wdata.red   = r_item.red;
                ram_wdata.green = r_item.green;
                ram_wdata.blue  = r_item.blue;
                if (r_found) begin
                    ram_we          = 1'b1;
                    ram_waddr       = addr_of(r_tbl, r_hit);
                    ram_wdata.count = sat_add(r_hitcnt, {24'd0, r_item.run_count});
                end else if (n_sel < FILL_W'(TABLE_DEPTH)) begin
                    ram_we          = 1'b1;
                    ram_waddr       = addr_of(r_tbl, n_sel[SLOT_W-1:0]);
                    ram_wdata.count = {24'd0, r_item.run_count};
                end
            end
            CMD_MERGE: begin
                ram_we          = (r_near != r_top);
                ram_waddr       = addr_of(r_tbl, r_top);
                ram_wdata       = r_top_ent;
                ram_wdata.count = sat_add(r_top_ent.count, r_nearcnt);
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HUE_TABLES; k++) r_fill[k] <= '0;
            r_tbl    <= '0;
            r_dcnt   <= '0;
            r_idx    <= '0;
            r_dv     <= 1'b0;
            r_dv2    <= 1'b0;
            r_found  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_dv  <= issue;
            r_dv2 <= r_dv && (i_cmd == CMD_NEAR_SCAN);
            if (issue) r_idx <= r_idx + FILL_W'(1);
            unique case (i_cmd)
                CMD_DIV_INIT: r_dcnt <= 5'(DIV_STEPS);
                CMD_DIV_STEP: if (r_dcnt != 5'd0) r_dcnt <= r_dcnt - 5'd1;
                CMD_PICK: begin
                    r_tbl   <= nearest_table(hue);
                    r_idx   <= '0;
                    r_found <= 1'b0;
                end
                CMD_MATCH_SCAN: begin
                    if (r_dv && !r_found &&
                        {ram_rdata.red, ram_rdata.green, ram_rdata.blue} ==
                        {r_item.red, r_item.green, r_item.blue}) begin
                        r_found <= 1'b1;
                    end
                end
                CMD_UPDATE: begin
                    if (!r_found && n_sel < FILL_W'(TABLE_DEPTH)) begin
                        r_fill[r_tbl] <= n_sel + FILL_W'(1);
                    end
                end
                CMD_BIG: begin
                    r_tbl   <= big;
                    r_idx   <= '0;
                    r_found <= 1'b0;
                end
                CMD_NEAR_INIT: r_idx <= '0;
                CMD_MERGE:     r_idx <= FILL_W'(r_near) + FILL_W'(1);
                CMD_DROP:      r_fill[r_tbl] <= n_sel - FILL_W'(1);
                default: begin
                end
            endcase
            // output register
            if (i_out_ctl == OUT_LOAD) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_didx <= r_idx[SLOT_W-1:0];
        unique case (i_cmd)
            CMD_LOAD: begin
                if (i_in_valid) r_item <= i_in_item;
                r_was_new <= 1'b0;
                r_merged  <= 1'b0;
                r_rd_ok   <= 1'b0;
            end
            CMD_DIV_INIT: begin
                r_num <= init_num;
                r_den <= (dd8 == 8'd0) ? 8'd1 : dd8;
                r_neg <= init_neg;
                r_rem <= '0;
                r_quo <= '0;
            end
            CMD_DIV_STEP: begin
                if (r_dcnt != 5'd0) begin
                    r_num <= {r_num[15:0], 1'b0};
                    r_rem <= div_bit ? 8'(div_t - {1'b0, r_den}) : div_t[7:0];
                    r_quo <= {r_quo[15:0], div_bit};
                end
            end
            CMD_PICK:     r_pick <= nearest_table(hue);
            CMD_MATCH_SCAN: begin
                if (r_dv && !r_found) begin
                    r_hit    <= r_didx;
                    r_hitcnt <= ram_rdata.count;
                end
            end
            CMD_UPDATE: begin
                if (!r_found && n_sel < FILL_W'(TABLE_DEPTH)) r_was_new <= 1'b1;
            end
            CMD_TOP_SCAN: begin
                if (r_dv && (r_didx == '0 || r_top_ent.count < ram_rdata.count)) begin
                    r_top     <= r_didx;
                    r_top_ent <= ram_rdata;
                end
            end
            CMD_NEAR_INIT: begin
                r_best <= '1;
                r_near <= '0;
            end
            CMD_NEAR_SCAN: begin
                if (r_dv) begin
                    r_sq_r  <= p_r[15:0];
                    r_sq_g  <= p_g[15:0];
                    r_sq_b  <= p_b[15:0];
                    r_didx2 <= r_didx;
                    r_cnt2  <= ram_rdata.count;
                end
                if (r_dv2 && r_didx2 != r_top && sq_dist < r_best) begin
                    r_best    <= sq_dist;
                    r_near    <= r_didx2;
                    r_nearcnt <= r_cnt2;
                end
            end
            CMD_DROP:     r_merged <= 1'b1;
            CMD_READ:     r_rd_ok  <= rd_ok_c;
            CMD_READ_CAP: r_ent    <= ram_rdata;
            default: begin
            end
        endcase
        if (i_out_ctl == OUT_LOAD) begin
            r_out.bucket          <= r_item.mode ? r_item.read_bucket : r_pick;
            r_out.was_new         <= r_was_new;
            r_out.merged          <= r_merged;
            r_out.entry_valid     <= r_item.mode && r_rd_ok;
            r_out.entry_red       <= (r_item.mode && r_rd_ok) ? r_ent.red : 8'd0;
            r_out.entry_green     <= (r_item.mode && r_rd_ok) ? r_ent.green : 8'd0;
            r_out.entry_blue      <= (r_item.mode && r_rd_ok) ? r_ent.blue : 8'd0;
            r_out.entry_frequency <= (r_item.mode && r_rd_ok) ? r_ent.count : 32'd0;
            r_out.total_entries   <= 9'(fill_sum);
        end
    end

    // status to the sequencer
    always_comb begin
        o_status.div_done     = (r_dcnt == 5'd0);
        o_status.scan_done    = r_found || ((r_idx >= n_sel) && !r_dv && !r_dv2);
        o_status.over_limit   = (fill_sum > SUM_W'(i_palette_limit));
        o_status.big_nonempty = (r_fill[big] != '0);
        o_status.mode_read    = r_item.mode;
        o_status.out_busy     = r_ovalid && i_out_stall;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

@@ rtl/hue_bucketed_palette_reducer.sv @@
// ----------------------------------------------------------------------------
// hue_bucketed_palette_reducer
// Builds a reduced palette in six hue tables from a stream of colour runs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) takes one item: an
//   insert of a colour run or a read of one stored entry. The output channel
//   (o_out_valid / i_out_stall / o_out_item) gives one result per item.
//   One item is processed at a time; o_in_stall is high while it is at work.
//   On an insert with merge the top scan, nearest scan and the shift each
//   sweep the largest table in the entry RAM through its single read port.
//   The hue divider takes 17 steps on every insert.
//   A finished result waits in the output register; the next item is taken
//   meanwhile, and its result waits while i_out_stall is high.
//   Reset empties all tables at once (fill counters only, no clearing pass)
//   and sets palette_limit to 216. palette_limit sits at APB address 0.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hue_bucketed_palette_reducer_defines.svh"

module hue_bucketed_palette_reducer import hbpr_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in_item,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out_item,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [7:0] r_limit;
    t_cmd       cmd;
    t_out_ctl   out_ctl;
    t_status    status;
    logic       busy;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_limit <= pwdata[7:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {24'd0, r_limit};

    hbpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_out_ctl  (out_ctl),
        .o_busy     (busy)
    );

    hbpr_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_out_ctl       (out_ctl),
        .o_status        (status),
        .i_in_valid      (i_in_valid),
        .i_in_item       (i_in_item),
        .i_palette_limit (r_limit),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_out_item      (o_out_item)
    );

    assign o_in_stall = busy;

    // checks
    `HBPR_ASSERT_NXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall, "idle after accept")
    `HBPR_ASSERT_IMP(a_total_bound, o_out_valid, o_out_item.total_entries <= 9'd256, "total too large")
    `HBPR_ASSERT_IMP(a_read_flags, o_out_valid && o_out_item.entry_valid, !o_out_item.was_new && !o_out_item.merged, "read result with insert flags")

endmodule

`default_nettype wire
